// ===== hdl/pir_pkg.sv =====
package pir_pkg;

    // Square root unit geometry: a 64-bit radicand gives a 32-bit floor root
    localparam int ISQ_IN_W   = 64;
    localparam int ISQ_ROOT_W = ISQ_IN_W / 2;
    localparam int ISQ_REM_W  = ISQ_ROOT_W + 2;
    localparam int ISQ_STEPS  = 2;
    localparam int ISQ_STAGES = ISQ_ROOT_W / ISQ_STEPS;

    // Sum of three squared 33-bit magnitudes
    localparam int D2_W = 66;

    localparam logic signed [31:0] LEN_RESET    = 32'sd66;
    localparam logic        [30:0] RADIUS_RESET = 31'd66;

    typedef enum logic [1:0] {
        OP_INSIDE     = 2'd0,
        OP_TOUCH      = 2'd1,
        OP_TOUCH_AXIS = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SHAPE_BOX    = 2'd0,
        SHAPE_CYL    = 2'd1,
        SHAPE_SPHERE = 2'd2
    } shape_t;

    typedef enum logic [3:0] {
        CFG_SHAPE_KIND = 4'd0,
        CFG_POS_X      = 4'd1,
        CFG_POS_Y      = 4'd2,
        CFG_POS_Z      = 4'd3,
        CFG_LEN_X      = 4'd4,
        CFG_LEN_Y      = 4'd5,
        CFG_LEN_Z      = 4'd6,
        CFG_RADIUS     = 4'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // Per-transaction data that rides alongside the square root unit
    typedef struct packed {
        logic            op_ok;
        logic            is_sphere;
        logic            early_hit;
        logic            use_sqrt;
        logic [30:0]     m_s;
        logic [D2_W-1:0] d2;
    } sph_side_t;

    typedef struct packed {
        logic [ISQ_IN_W-1:0]   x;
        logic [ISQ_REM_W-1:0]  rem;
        logic [ISQ_ROOT_W-1:0] root;
    } isq_state_t;

    // One digit-by-digit square root step: consume two radicand bits,
    // resolve one root bit
    function automatic isq_state_t isq_step(input isq_state_t s);
        isq_state_t           r;
        logic [ISQ_REM_W+1:0] work;
        logic [ISQ_REM_W+1:0] trial;
        work  = {s.rem, s.x[ISQ_IN_W-1 -: 2]};
        trial = (ISQ_REM_W + 2)'({s.root, 2'b01});
        r.x   = {s.x[ISQ_IN_W-3:0], 2'b00};
        if (work >= trial)
        begin
            r.rem  = ISQ_REM_W'(work - trial);
            r.root = {s.root[ISQ_ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = ISQ_REM_W'(work);
            r.root = {s.root[ISQ_ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== hdl/point_in_primitive_region_test.sv =====
// Channel   Handshake            Payload
// cfg       cfg_valid/cfg_ready  cfg_index[3:0], cfg_data[31:0]
// in        in_valid/in_stall    opcode, point_x/y/z, margin, margin_x/y/z
// out       out_valid/out_stall  hit
//
// One query point per cycle sustained while the output is not stalled. The
// pipeline has 23 register stages: four front stages (margin select and
// offsets, bound compares and magnitudes, squares, squared-distance sums),
// sixteen margin-vector square root stages at two root bits each, then limit
// add, limit square, and the final compare into the output register.
// Reset clears all valid bits and loads the register reset values; cfg_ready
// is always high. A stall on the output backs up stage by stage: each stage
// still loads while it is empty, so bubbles are squeezed out and in_stall
// rises only when the first stage holds a transaction that cannot advance.
module point_in_primitive_region_test
    import pir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [30:0]        margin,
    input  logic [30:0]        margin_x,
    input  logic [30:0]        margin_y,
    input  logic [30:0]        margin_z,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit
);

    // ------------------------------------------------------------------
    // Region registers. The user must write them only while the pipeline
    // is drained, so every stage reads them directly; no logic enforces it.
    // ------------------------------------------------------------------
    logic [1:0]         shape_kind_reg;
    logic signed [31:0] region_pos_x_reg;
    logic signed [31:0] region_pos_y_reg;
    logic signed [31:0] region_pos_z_reg;
    logic signed [31:0] region_len_x_reg;
    logic signed [31:0] region_len_y_reg;
    logic signed [31:0] region_len_z_reg;
    logic [30:0]        region_radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_kind_reg    <= SHAPE_BOX;
            region_pos_x_reg  <= '0;
            region_pos_y_reg  <= '0;
            region_pos_z_reg  <= '0;
            region_len_x_reg  <= LEN_RESET;
            region_len_y_reg  <= LEN_RESET;
            region_len_z_reg  <= LEN_RESET;
            region_radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SHAPE_KIND: shape_kind_reg    <= cfg_data[1:0];
                CFG_POS_X:      region_pos_x_reg  <= cfg_data;
                CFG_POS_Y:      region_pos_y_reg  <= cfg_data;
                CFG_POS_Z:      region_pos_z_reg  <= cfg_data;
                CFG_LEN_X:      region_len_x_reg  <= cfg_data;
                CFG_LEN_Y:      region_len_y_reg  <= cfg_data;
                CFG_LEN_Z:      region_len_z_reg  <= cfg_data;
                CFG_RADIUS:     region_radius_reg <= cfg_data[30:0];
                default:        ; // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage payloads
    // ------------------------------------------------------------------
    typedef struct packed {
        logic               op_ok;
        logic               use_sqrt;
        logic [30:0]        m_s;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic [30:0]        mx;
        logic [30:0]        my;
        logic [30:0]        mz;
        logic [61:0]        msq_x;
        logic [61:0]        msq_y;
        logic [61:0]        msq_z;
    } stg_a_t;

    typedef struct packed {
        logic                op_ok;
        logic                use_sqrt;
        logic [30:0]         m_s;
        logic                box_hit;
        logic [2:0]          span;
        logic [32:0]         ax;
        logic [32:0]         ay;
        logic [32:0]         az;
        logic [ISQ_IN_W-1:0] msum;
    } stg_b_t;

    typedef struct packed {
        logic                op_ok;
        logic                use_sqrt;
        logic [30:0]         m_s;
        logic                box_hit;
        logic                cyl_span;
        axis_t               axis;
        logic [64:0]         sqx;
        logic [64:0]         sqy;
        logic [64:0]         sqz;
        logic [61:0]         r2;
        logic [ISQ_IN_W-1:0] msum;
    } stg_c_t;

    typedef struct packed {
        logic            op_ok;
        logic            is_sphere;
        logic            early_hit;
        logic [D2_W-1:0] d2;
        logic [32:0]     lim;
    } stg_e_t;

    typedef struct packed {
        logic            op_ok;
        logic            is_sphere;
        logic            early_hit;
        logic [D2_W-1:0] d2;
        logic            lim_hi;
        logic [31:0]     lim_lo;
        logic [63:0]     lo_sq;
    } stg_f_t;

    stg_a_t a_reg, a_next;
    stg_b_t b_reg, b_next;
    stg_c_t c_reg, c_next;
    sph_side_t d_side_reg, d_side_next;
    logic [ISQ_IN_W-1:0] d_msum_reg;
    stg_e_t e_reg, e_next;
    stg_f_t f_reg, f_next;
    logic hit_reg, hit_next;

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic e_valid_reg, f_valid_reg, out_valid_reg;

    logic a_ready, b_ready, c_ready, d_ready, e_ready, f_ready, g_ready;

    logic                  isq_in_ready;
    logic                  isq_out_valid;
    logic [ISQ_ROOT_W-1:0] isq_root;
    sph_side_t             isq_side;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Strict box bound on one axis: d + m > 0 and d - m < len, d = p - pos
    function automatic logic box_axis(input logic signed [32:0] d,
                                      input logic [30:0] m,
                                      input logic signed [31:0] len);
        logic signed [34:0] dw;
        logic signed [34:0] mw;
        logic signed [34:0] lw;
        dw = 35'(d);
        mw = $signed({4'b0000, m});
        lw = 35'(len);
        return ((dw + mw) > 35'sd0) && ((dw - mw) < lw);
    endfunction

    function automatic logic span_axis(input logic signed [32:0] d,
                                       input logic signed [31:0] len);
        return (d > 33'sd0) && (d < 33'(len));
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] d);
        return d[32] ? (~d + 33'd1) : d;
    endfunction

    // Magnitude never exceeds 2^32, so the top bit alone means 2^64
    function automatic logic [64:0] mag_sq(input logic [32:0] a);
        logic [63:0] p;
        p = a[31:0] * a[31:0];
        return a[32] ? {1'b1, 64'd0} : {1'b0, p};
    endfunction

    // ------------------------------------------------------------------
    // Handshake chain: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    assign g_ready = !out_valid_reg || !out_stall;
    assign f_ready = !f_valid_reg || g_ready;
    assign e_ready = !e_valid_reg || f_ready;
    assign d_ready = !d_valid_reg || isq_in_ready;
    assign c_ready = !c_valid_reg || d_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;

    assign in_stall  = !a_ready;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    // ------------------------------------------------------------------
    // Stage A: decode opcode, pick margins, offsets from region origin,
    // squares of the margin vector
    // ------------------------------------------------------------------
    always_comb
    begin
        a_next.op_ok    = 1'b1;
        a_next.use_sqrt = 1'b0;
        a_next.m_s      = '0;
        a_next.mx       = '0;
        a_next.my       = '0;
        a_next.mz       = '0;
        unique case (op_t'(opcode))
            OP_INSIDE: ;
            OP_TOUCH:
            begin
                a_next.m_s = margin;
                a_next.mx  = margin;
                a_next.my  = margin;
                a_next.mz  = margin;
            end
            OP_TOUCH_AXIS:
            begin
                a_next.use_sqrt = 1'b1;
                a_next.mx       = margin_x;
                a_next.my       = margin_y;
                a_next.mz       = margin_z;
            end
            default: a_next.op_ok = 1'b0;
        endcase
        a_next.dx    = {point_x[31], point_x} - {region_pos_x_reg[31], region_pos_x_reg};
        a_next.dy    = {point_y[31], point_y} - {region_pos_y_reg[31], region_pos_y_reg};
        a_next.dz    = {point_z[31], point_z} - {region_pos_z_reg[31], region_pos_z_reg};
        a_next.msq_x = margin_x * margin_x;
        a_next.msq_y = margin_y * margin_y;
        a_next.msq_z = margin_z * margin_z;
    end

    // ------------------------------------------------------------------
    // Stage B: box and cylinder interval tests, offset magnitudes,
    // margin vector squared length
    // ------------------------------------------------------------------
    always_comb
    begin
        b_next.op_ok    = a_reg.op_ok;
        b_next.use_sqrt = a_reg.use_sqrt;
        b_next.m_s      = a_reg.m_s;
        b_next.box_hit  = box_axis(a_reg.dx, a_reg.mx, region_len_x_reg) &&
                          box_axis(a_reg.dy, a_reg.my, region_len_y_reg) &&
                          box_axis(a_reg.dz, a_reg.mz, region_len_z_reg);
        b_next.span[0]  = span_axis(a_reg.dx, region_len_x_reg);
        b_next.span[1]  = span_axis(a_reg.dy, region_len_y_reg);
        b_next.span[2]  = span_axis(a_reg.dz, region_len_z_reg);
        b_next.ax       = mag33(a_reg.dx);
        b_next.ay       = mag33(a_reg.dy);
        b_next.az       = mag33(a_reg.dz);
        b_next.msum     = ISQ_IN_W'(a_reg.msq_x) + ISQ_IN_W'(a_reg.msq_y) +
                          ISQ_IN_W'(a_reg.msq_z);
    end

    // ------------------------------------------------------------------
    // Stage C: squared offsets, radius squared, cylinder axis pick
    // (first nonzero length, X then Y then Z)
    // ------------------------------------------------------------------
    always_comb
    begin
        c_next.op_ok    = b_reg.op_ok;
        c_next.use_sqrt = b_reg.use_sqrt;
        c_next.m_s      = b_reg.m_s;
        c_next.box_hit  = b_reg.box_hit;
        c_next.sqx      = mag_sq(b_reg.ax);
        c_next.sqy      = mag_sq(b_reg.ay);
        c_next.sqz      = mag_sq(b_reg.az);
        c_next.r2       = region_radius_reg * region_radius_reg;
        c_next.msum     = b_reg.msum;
        if (region_len_x_reg != 32'sd0)
        begin
            c_next.axis     = AXIS_X;
            c_next.cyl_span = b_reg.span[0];
        end
        else if (region_len_y_reg != 32'sd0)
        begin
            c_next.axis     = AXIS_Y;
            c_next.cyl_span = b_reg.span[1];
        end
        else if (region_len_z_reg != 32'sd0)
        begin
            c_next.axis     = AXIS_Z;
            c_next.cyl_span = b_reg.span[2];
        end
        else
        begin
            // all lengths zero: no cylinder, never a hit
            c_next.axis     = AXIS_NONE;
            c_next.cyl_span = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: sphere distance, cylinder radial compare, resolve box and
    // cylinder answers; the sphere answer waits on the square root
    // ------------------------------------------------------------------
    logic [D2_W-1:0] cyl_pair;
    logic            cyl_hit;

    always_comb
    begin
        unique case (c_reg.axis)
            AXIS_X:    cyl_pair = D2_W'(c_reg.sqy) + D2_W'(c_reg.sqz);
            AXIS_Y:    cyl_pair = D2_W'(c_reg.sqx) + D2_W'(c_reg.sqz);
            AXIS_Z:    cyl_pair = D2_W'(c_reg.sqx) + D2_W'(c_reg.sqy);
            AXIS_NONE: cyl_pair = '0;
        endcase
        cyl_hit = c_reg.cyl_span && (cyl_pair < D2_W'(c_reg.r2));

        d_side_next.op_ok     = c_reg.op_ok;
        d_side_next.is_sphere = (shape_kind_reg == SHAPE_SPHERE);
        d_side_next.use_sqrt  = c_reg.use_sqrt;
        d_side_next.m_s       = c_reg.m_s;
        d_side_next.d2        = D2_W'(c_reg.sqx) + D2_W'(c_reg.sqy) + D2_W'(c_reg.sqz);
        unique case (shape_kind_reg)
            SHAPE_BOX: d_side_next.early_hit = c_reg.box_hit;
            SHAPE_CYL: d_side_next.early_hit = cyl_hit;
            default:   d_side_next.early_hit = 1'b0;
        endcase
    end

    // Margin vector length: floor square root of the squared length
    pir_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid_reg),
        .in_ready  (isq_in_ready),
        .in_x      (d_msum_reg),
        .in_side   (d_side_reg),
        .out_valid (isq_out_valid),
        .out_ready (e_ready),
        .out_root  (isq_root),
        .out_side  (isq_side)
    );

    // ------------------------------------------------------------------
    // Stage E: sphere limit = radius + margin length
    // ------------------------------------------------------------------
    always_comb
    begin
        e_next.op_ok     = isq_side.op_ok;
        e_next.is_sphere = isq_side.is_sphere;
        e_next.early_hit = isq_side.early_hit;
        e_next.d2        = isq_side.d2;
        e_next.lim       = 33'(region_radius_reg) +
                           (isq_side.use_sqrt ? 33'(isq_root) : 33'(isq_side.m_s));
    end

    // ------------------------------------------------------------------
    // Stage F: square the low 32 bits of the limit
    // ------------------------------------------------------------------
    always_comb
    begin
        f_next.op_ok     = e_reg.op_ok;
        f_next.is_sphere = e_reg.is_sphere;
        f_next.early_hit = e_reg.early_hit;
        f_next.d2        = e_reg.d2;
        f_next.lim_hi    = e_reg.lim[32];
        f_next.lim_lo    = e_reg.lim[31:0];
        f_next.lo_sq     = e_reg.lim[31:0] * e_reg.lim[31:0];
    end

    // ------------------------------------------------------------------
    // Stage G: fold in the top limit bit, final compare, pick the answer
    // ------------------------------------------------------------------
    logic [D2_W-1:0] lim_sq;

    always_comb
    begin
        lim_sq   = D2_W'(f_reg.lo_sq) +
                   (f_reg.lim_hi ? ({1'b0, f_reg.lim_lo, 33'd0} + {2'b01, 64'd0})
                                 : {D2_W{1'b0}});
        hit_next = f_reg.op_ok &&
                   (f_reg.is_sphere ? (f_reg.d2 < lim_sq) : f_reg.early_hit);
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready) a_valid_reg   <= in_valid;
            if (b_ready) b_valid_reg   <= a_valid_reg;
            if (c_ready) c_valid_reg   <= b_valid_reg;
            if (d_ready) d_valid_reg   <= c_valid_reg;
            if (e_ready) e_valid_reg   <= isq_out_valid;
            if (f_ready) f_valid_reg   <= e_valid_reg;
            if (g_ready) out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready) a_reg <= a_next;
        if (b_ready) b_reg <= b_next;
        if (c_ready) c_reg <= c_next;
        if (d_ready)
        begin
            d_side_reg <= d_side_next;
            d_msum_reg <= c_reg.msum;
        end
        if (e_ready) e_reg   <= e_next;
        if (f_ready) f_reg   <= f_next;
        if (g_ready) hit_reg <= hit_next;
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> a_valid_reg)
        else $error("input stalled with an empty first stage");

    a_d_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && !isq_in_ready) |=> (d_valid_reg && $stable(d_side_reg)))
        else $error("stage D transaction changed while blocked");

    a_bad_op_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (g_ready && f_valid_reg && !f_reg.op_ok) |=> (out_valid_reg && !hit_reg))
        else $error("unused opcode reported a hit");

endmodule

// ===== hdl/pir_isqrt.sv =====
module pir_isqrt
    import pir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ISQ_IN_W-1:0]   in_x,
    input  sph_side_t             in_side,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ISQ_ROOT_W-1:0] out_root,
    output sph_side_t             out_side
);

    logic              valid_reg [ISQ_STAGES];
    isq_state_t        st_reg    [ISQ_STAGES];
    sph_side_t         side_reg  [ISQ_STAGES];
    logic [ISQ_STAGES:0] stage_ready;

    assign stage_ready[ISQ_STAGES] = out_ready;

    genvar s;
    for (s = 0; s < ISQ_STAGES; s++)
    begin : g_stage
        logic       valid_src;
        isq_state_t state_src;
        isq_state_t stage_next;
        sph_side_t  side_src;

        if (s == 0)
        begin : g_first
            assign valid_src = in_valid;
            assign state_src = '{x: in_x, rem: '0, root: '0};
            assign side_src  = in_side;
        end
        else
        begin : g_rest
            assign valid_src = valid_reg[s-1];
            assign state_src = st_reg[s-1];
            assign side_src  = side_reg[s-1];
        end

        // advance when empty or when the next stage takes our transaction
        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];

        always_comb
        begin
            stage_next = state_src;
            for (int k = 0; k < ISQ_STEPS; k++)
            begin
                stage_next = isq_step(stage_next);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (stage_ready[s])
            begin
                valid_reg[s] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[s])
            begin
                st_reg[s]   <= stage_next;
                side_reg[s] <= side_src;
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[ISQ_STAGES-1];
    assign out_root  = st_reg[ISQ_STAGES-1].root;
    assign out_side  = side_reg[ISQ_STAGES-1];

    // final remainder of a floor root never exceeds twice the root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (st_reg[ISQ_STAGES-1].rem <= {1'b0, out_root, 1'b0}))
        else $error("square root remainder out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_root)))
        else $error("square root result lost while held");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pir_pkg::*;

    // Codes the package leaves unnamed: the spare opcode and the spare shape
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] SHAPE_UNUSED = 2'd3;
    // Register indexes at and above this one address nothing
    localparam int         CFG_COUNT    = 8;

    localparam logic signed [31:0] MIN_P = 32'sh8000_0000;
    localparam logic signed [31:0] MAX_P = 32'sh7FFF_FFFF;
    localparam logic        [30:0] MAX_M = 31'h7FFF_FFFF;
    localparam int                 ONE   = 1 << 16;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 30;
    localparam int CYCLE_LIMIT = 200_000;

    typedef struct {
        logic [1:0]         opcode;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [30:0]        margin;
        logic [30:0]        mx;
        logic [30:0]        my;
        logic [30:0]        mz;
    } query_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_index = '0;
    logic [31:0]        cfg_data  = '0;

    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode    = '0;
    logic signed [31:0] point_x   = '0;
    logic signed [31:0] point_y   = '0;
    logic signed [31:0] point_z   = '0;
    logic [30:0]        margin    = '0;
    logic [30:0]        margin_x  = '0;
    logic [30:0]        margin_y  = '0;
    logic [30:0]        margin_z  = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               hit;

    // Shadow copy of the region registers, updated on each accepted write
    logic [1:0]         region_shape  = SHAPE_BOX;
    logic signed [31:0] region_pos [3] = '{32'sd0, 32'sd0, 32'sd0};
    logic signed [31:0] region_len [3] = '{LEN_RESET, LEN_RESET, LEN_RESET};
    logic [30:0]        region_rad    = RADIUS_RESET;

    query_t query_q [$];        // queries waiting to be offered
    query_t cur_query;          // query currently on the input port
    bit     expected_hits [$];  // predicted answers, oldest first

    int idle_pct      = 19;
    int stall_pct     = 19;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    point_in_primitive_region_test uut (.*);

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Open interval test on one axis, widened by the margin on both sides
    function automatic bit spans_axis(longint p, longint m, longint pos, longint len);
        return (p + m > pos) && (p - m < pos + len);
    endfunction

    // Exact squared distance along one axis, 128 bits wide
    function automatic logic [127:0] axis_sq(longint p, longint c);
        longint      d;
        logic [63:0] u;
        d = p - c;
        u = (d < 0) ? -d : d;
        return {64'd0, u} * {64'd0, u};
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // Cylinder axis is the first nonzero length; 3 means no axis at all
    function automatic int cylinder_axis();
        for (int a = 0; a < 3; a++)
            if (region_len[a] != 0)
                return a;
        return 3;
    endfunction

    function automatic bit point_hits_region(query_t q);
        longint       p [3];
        longint       mg [3];
        longint       m;
        logic [63:0]  u;
        logic [63:0]  msq;
        logic [63:0]  lim;
        logic [127:0] d2;
        logic [127:0] r2;
        int           ax;
        bit           hits;
        p[0]  = q.px;
        p[1]  = q.py;
        p[2]  = q.pz;
        m     = q.margin;
        mg[0] = q.mx;
        mg[1] = q.my;
        mg[2] = q.mz;
        if (q.opcode == OP_INSIDE)
        begin
            m  = 0;
            mg = '{0, 0, 0};
        end
        else if (q.opcode == OP_TOUCH)
            mg = '{m, m, m};
        hits = 1'b0;
        if (q.opcode != OP_UNUSED)
        begin
            case (region_shape)
                SHAPE_BOX:
                    hits = spans_axis(p[0], mg[0], region_pos[0], region_len[0]) &&
                           spans_axis(p[1], mg[1], region_pos[1], region_len[1]) &&
                           spans_axis(p[2], mg[2], region_pos[2], region_len[2]);
                SHAPE_CYL:
                begin
                    // margins play no part for a cylinder
                    ax = cylinder_axis();
                    if (ax < 3)
                    begin
                        d2 = '0;
                        for (int a = 0; a < 3; a++)
                            if (a != ax)
                                d2 += axis_sq(p[a], region_pos[a]);
                        r2   = {97'd0, region_rad} * {97'd0, region_rad};
                        hits = spans_axis(p[ax], 0, region_pos[ax], region_len[ax]) &&
                               (d2 < r2);
                    end
                end
                SHAPE_SPHERE:
                begin
                    if (q.opcode == OP_TOUCH_AXIS)
                    begin
                        // margin vector length, floored
                        msq = '0;
                        for (int a = 0; a < 3; a++)
                        begin
                            u   = mg[a];
                            msq += u * u;
                        end
                        lim = 64'(region_rad) + floor_sqrt(msq);
                    end
                    else
                        lim = 64'(region_rad) + 64'(m);
                    d2 = '0;
                    for (int a = 0; a < 3; a++)
                        d2 += axis_sq(p[a], region_pos[a]);
                    hits = d2 < ({64'd0, lim} * {64'd0, lim});
                end
                SHAPE_UNUSED:
                    hits = 1'b0;
            endcase
        end
        return hits;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic query_t make_query(logic [1:0] op, logic signed [31:0] x,
                                          logic signed [31:0] y, logic signed [31:0] z,
                                          logic [30:0] m, logic [30:0] mx,
                                          logic [30:0] my, logic [30:0] mz);
        query_t q;
        q.opcode = op;
        q.px     = x;
        q.py     = y;
        q.pz     = z;
        q.margin = m;
        q.mx     = mx;
        q.my     = my;
        q.mz     = mz;
        return q;
    endfunction

    // Mostly near the span [lo, hi], some exactly on its ends, some anywhere
    function automatic logic signed [31:0] pick_coord(longint lo, longint hi);
        longint      t;
        longint      slack;
        longint      span;
        longint      v;
        logic [63:0] r;
        if (hi < lo)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        slack = (hi - lo) / 4 + 2;
        span  = hi - lo + 2 * slack;
        r     = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0, 1, 2: v = int'($urandom);
            3:       v = lo;
            4:       v = hi;
            5:       v = lo + 1;
            6:       v = hi - 1;
            7:       v = lo - 1;
            8:       v = hi + 1;
            default: v = lo - slack + longint'(r % span);
        endcase
        return v[31:0];
    endfunction

    function automatic logic [30:0] pick_margin(longint scale);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2, 3:    return 31'($urandom);
            4:       return MAX_M;
            default: return 31'(r % (scale + 1));
        endcase
    endfunction

    // Aim the point at the configured region so that both answers are common
    function automatic query_t random_query();
        query_t q;
        longint lo [3];
        longint hi [3];
        longint rad;
        longint scale;
        longint mag;
        int     ax;
        ax    = cylinder_axis();
        rad   = region_rad;
        scale = rad;
        for (int a = 0; a < 3; a++)
        begin
            mag = region_len[a];
            if (mag < 0)
                mag = -mag;
            if (mag > scale)
                scale = mag;
            lo[a] = region_pos[a];
            if (region_shape == SHAPE_BOX || (region_shape == SHAPE_CYL && a == ax))
                hi[a] = lo[a] + region_len[a];
            else
            begin
                hi[a] = lo[a] + rad;
                lo[a] = lo[a] - rad;
            end
        end
        scale    = scale / 2 + 1;
        q.opcode = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
        q.px     = pick_coord(lo[0], hi[0]);
        q.py     = pick_coord(lo[1], hi[1]);
        q.pz     = pick_coord(lo[2], hi[2]);
        q.margin = pick_margin(scale);
        q.mx     = pick_margin(scale);
        q.my     = pick_margin(scale);
        q.mz     = pick_margin(scale);
        return q;
    endfunction

    // Drive one register write and track it in the shadow copy
    task automatic write_reg(logic [3:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SHAPE_KIND: region_shape  = data[1:0];
            CFG_POS_X:      region_pos[0] = data;
            CFG_POS_Y:      region_pos[1] = data;
            CFG_POS_Z:      region_pos[2] = data;
            CFG_LEN_X:      region_len[0] = data;
            CFG_LEN_Y:      region_len[1] = data;
            CFG_LEN_Z:      region_len[2] = data;
            CFG_RADIUS:     region_rad    = data[30:0];
            default:        ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic load_region(logic [31:0] shape, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z,
                               logic signed [31:0] lx, logic signed [31:0] ly,
                               logic signed [31:0] lz, logic [31:0] rad);
        write_reg(CFG_SHAPE_KIND, shape);
        write_reg(CFG_POS_X, x);
        write_reg(CFG_POS_Y, y);
        write_reg(CFG_POS_Z, z);
        write_reg(CFG_LEN_X, lx);
        write_reg(CFG_LEN_Y, ly);
        write_reg(CFG_LEN_Z, lz);
        write_reg(CFG_RADIUS, rad);
    endtask

    // Sample on the falling edge so the driver's pop and valid have settled
    task automatic wait_drained();
        do @(negedge clk);
        while (query_q.size() != 0 || in_valid || expected_hits.size() != 0);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            query_q.push_back(random_query());
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued queries, predict each accepted transaction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_hits.push_back(point_hits_region(cur_query));
            // hold the payload while stalled, otherwise load the next query or idle
            if (!in_valid || !in_stall)
            begin
                if (query_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    cur_query = query_q.pop_front();
                    in_valid <= 1'b1;
                    opcode   <= cur_query.opcode;
                    point_x  <= cur_query.px;
                    point_y  <= cur_query.py;
                    point_z  <= cur_query.pz;
                    margin   <= cur_query.margin;
                    margin_x <= cur_query.mx;
                    margin_y <= cur_query.my;
                    margin_z <= cur_query.mz;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result, drive random and long stalls
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual hit %0b",
                             $time, hit);
                    fail_count++;
                end
                else if (hit !== expected_hits[0])
                begin
                    $display("%0t: hit mismatch, expected %0b, actual %0b",
                             $time, expected_hits[0], hit);
                    fail_count++;
                    void'(expected_hits.pop_front());
                end
                else
                    void'(expected_hits.pop_front());
            end
            // a requested hold-off stalls the output while hold_left counts down
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served <= holds_served + 1;
                hold_left    <= HOLD_CYCLES;
                out_stall    <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset region is the open box (0, 66) on every axis: probe its strict
        // faces, each opcode, and the extremes of points and margins
        query_q.push_back(make_query(OP_INSIDE, 33, 33, 33, 0, 0, 0, 0));
        query_q.push_back(make_query(OP_INSIDE, 0, 33, 33, MAX_M, MAX_M, 0, 0));
        query_q.push_back(make_query(OP_INSIDE, 66, 33, 33, 0, 0, 0, 0));
        query_q.push_back(make_query(OP_INSIDE, 1, 65, 1, 0, 0, 0, 0));
        query_q.push_back(make_query(OP_TOUCH, 0, 33, 33, 1, 0, 0, 0));
        query_q.push_back(make_query(OP_TOUCH, -5, -5, -5, 5, 9, 9, 9));
        query_q.push_back(make_query(OP_TOUCH, -5, -5, -5, 6, 0, 0, 0));
        query_q.push_back(make_query(OP_TOUCH_AXIS, -10, 70, 33, 0, 11, 5, 0));
        query_q.push_back(make_query(OP_TOUCH_AXIS, -10, 70, 33, 50, 10, 5, 0));
        query_q.push_back(make_query(OP_UNUSED, 33, 33, 33, 5, 5, 5, 5));
        query_q.push_back(make_query(OP_INSIDE, MIN_P, MIN_P, MIN_P, 0, 0, 0, 0));
        query_q.push_back(make_query(OP_INSIDE, MAX_P, MAX_P, MAX_P, 0, 0, 0, 0));
        query_q.push_back(make_query(OP_TOUCH, MAX_P, MAX_P, MAX_P, MAX_M, 0, 0, 0));
        query_q.push_back(make_query(OP_TOUCH, MIN_P, MIN_P, MIN_P, MAX_M, 0, 0, 0));
        query_q.push_back(make_query(OP_TOUCH_AXIS, MIN_P, MAX_P, 33, 0, MAX_M, MAX_M, 0));
        query_q.push_back(make_query(OP_TOUCH_AXIS, 0, 0, 0, 0, MAX_M, MAX_M, MAX_M));
        run_random(60);

        // Wide box; hold off the output so the pipeline fills and stalls its input
        load_region(SHAPE_BOX, -1000000, -70000, 100, 2000000, 2000000, 3000000,
                    $urandom);
        hold_requests++;
        run_random(100);

        // Box at the extremes of position and length, with a one-wide z span
        load_region(SHAPE_BOX, MIN_P, MAX_P, MIN_P, MAX_P, MAX_P, 1, 0);
        run_random(80);

        // Negative y extent: the box is empty
        load_region(SHAPE_BOX, 0, 0, 0, 1000, -1000, 1000, 66);
        run_random(40);

        // Cylinder along x; radius write carries a stray top bit, drop it
        load_region(SHAPE_CYL, 500, -300, 200, 4000, 7, -9, 32'h8000_05DC);
        hold_requests++;
        run_random(100);

        // Cylinder along y, then along z
        load_region(SHAPE_CYL, -2000, 0, 1500, 0, 5000, 3, 2000);
        run_random(80);
        load_region(SHAPE_CYL, -ONE, ONE, -10, 0, 0, 3 * ONE, ONE);
        run_random(80);

        // Cylinder with no axis, then one with a negative axis length
        load_region(SHAPE_CYL, 0, 0, 0, 0, 0, 0, 1000);
        run_random(30);
        load_region(SHAPE_CYL, 0, 0, 0, -4000, 0, 0, 1000);
        run_random(30);

        // Sphere at the origin, shape written with spare high bits; run without
        // any idling on either side
        load_region(32'h6, 0, 0, 0, MIN_P, 0, MAX_P, 66);
        idle_pct  = 0;
        stall_pct = 0;
        query_q.push_back(make_query(OP_INSIDE, 66, 0, 0, 0, 0, 0, 0));
        query_q.push_back(make_query(OP_INSIDE, 65, 0, 0, 0, 0, 0, 0));
        query_q.push_back(make_query(OP_TOUCH_AXIS, 70, 0, 0, 0, 3, 4, 0));
        query_q.push_back(make_query(OP_TOUCH_AXIS, 71, 0, 0, 0, 3, 4, 0));
        run_random(100);
        idle_pct  = 19;
        stall_pct = 19;

        // Largest sphere at extreme centre, then a sphere of zero radius
        load_region(SHAPE_SPHERE, MAX_P, MIN_P, MAX_P, 66, 66, 66, 32'hFFFF_FFFF);
        run_random(80);
        load_region(SHAPE_SPHERE, 0, 0, 0, 66, 66, 66, 0);
        run_random(40);

        // Unused shape code: never a hit
        load_region(32'hFFFF_FFFF, 0, 0, 0, 1000, 1000, 1000, 1000);
        run_random(20);

        // Writes past the last register must leave the box untouched
        load_region(SHAPE_BOX, -300, -300, -300, 900, 900, 900, 500);
        for (int i = CFG_COUNT; i < 16; i++)
            write_reg(4'(i), $urandom);
        @(negedge clk);
        run_random(80);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_hits.size() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, expected_hits.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pir_pkg.sv
hdl/pir_isqrt.sv
hdl/point_in_primitive_region_test.sv
tb/testbench.sv
